[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SM3 hash engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 package
// Constants, types and word functions shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   // Standard initial chaining value.
   localparam logic [31:0] IV_RESET [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

   localparam logic [31:0] T_LOW    = 32'h79CC4519;
   localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // Control word from the sequencer to the round unit.
   typedef struct packed {
      logic       start;
      logic       shift_en;
      logic [7:0] shift_byte;
   } sm3_ctrl_type;

   // Status from the round unit.
   typedef struct packed {
      logic done;
   } sm3_stat_type;

   // Rotate left by a constant amount in 1..31.
   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

[hdl/sm3_round_unit.sv]
// ----------------------------------------------------------------------------
// SM3 round unit
// Holds the message window and the round registers; loads bytes into the
// window and runs the 64 compression rounds, one round per cycle.
// ----------------------------------------------------------------------------
module sm3_round_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  sm3_pkg::sm3_ctrl_type ctrl,
   input  logic [31:0]           cv [8],
   output sm3_pkg::sm3_stat_type stat,
   output logic [31:0]           result [8]
);
   import sm3_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] r_ff [8];
   logic [31:0] r_in [8];
   logic [31:0] tj_ff, tj_in;
   logic [5:0]  round_ff, round_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, w_new;

   // One round of the compression function.
   always_comb begin
      a12 = rotl(r_ff[0], 12);
      ss1 = rotl(a12 + r_ff[4] + tj_ff, 7);
      ss2 = ss1 ^ a12;
      if (round_ff[5:4] == 2'b00) begin
         ffv = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         ggv = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ffv = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         ggv = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ffv + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = ggv + r_ff[7] + ss1 + w_ff[0];
      w_new = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 15)) ^ rotl(w_ff[3], 7) ^ w_ff[10];
   end

   // Next-state selection for window, round registers and counters.
   always_comb begin
      w_in     = w_ff;
      r_in     = r_ff;
      tj_in    = tj_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (busy_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_new;
         r_in[0] = tt1;
         r_in[1] = r_ff[0];
         r_in[2] = rotl(r_ff[1], 9);
         r_in[3] = r_ff[2];
         r_in[4] = perm0(tt2);
         r_in[5] = r_ff[4];
         r_in[6] = rotl(r_ff[5], 19);
         r_in[7] = r_ff[6];
         tj_in    = (round_ff == 6'd15) ? rotl(T_HIGH, 16) : rotl(tj_ff, 1);
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         r_in     = cv;
         tj_in    = T_LOW;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (ctrl.shift_en) begin
         // The window acts as one 512-bit shift line, first byte on top.
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], ctrl.shift_byte};
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      r_ff     <= r_in;
      tj_ff    <= tj_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Feed-forward into the chaining value.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         result[i] = cv[i] ^ r_ff[i];
      end
   end

   assign stat.done = done_ff;

endmodule

[hdl/sm3_hash_engine.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 hash: absorbs message bytes, pads on message end and
// returns the eight digest words.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// req_     | in        | tdata: data_byte, prefix_length; tuser: byte_present;
//          |           | tlast: message_end
// rsp_     | out       | tdata: digest_word, word_index; tlast: final_word
// csr_     | in/out    | APB access to iv_word_0..7 at 4*i
//
// A byte word is taken while the engine is idle; the 64th byte of a block
// starts a compression in the shared round unit (a load step, one round per
// cycle, then a fold of the result into the chaining value).
// An end word adds up to 72 padding bytes, one per cycle, and one or two
// compressions, then presents eight digest words, one per cycle if taken.
// req_tready is low while padding, compressing or returning the digest.
// Reset is synchronous and restores the standard initial value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] data_byte, [68:8] prefix_length
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sm3_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_OUT} state_type;

   state_type    state_ff, state_in, ret_ff, ret_in;
   logic [31:0]  iv_ff [8];
   logic [31:0]  cv_ff [8];
   logic [31:0]  cv_in [8];
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bc_ff, bc_in;
   logic         open_ff, open_in;
   logic         pad_first_ff, pad_first_in;
   logic         len_ok_ff, len_ok_in, len_ok_cur;
   logic [2:0]   idx_ff, idx_in;
   logic         start_ff, start_in;

   logic [63:0]  bc_base, bits;
   logic [5:0]   fill_base;
   logic         req_acc, rsp_acc;
   sm3_ctrl_type ctrl;
   sm3_stat_type stat;
   logic [31:0]  result [8];

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign bits    = {bc_ff[60:0], 3'b000};

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = iv_ff[csr_paddr[4:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= IV_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         iv_ff[csr_paddr[4:2]] <= csr_pwdata;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cv_in        = cv_ff;
      fill_in      = fill_ff;
      bc_in        = bc_ff;
      open_in      = open_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      idx_in       = idx_ff;
      start_in     = 1'b0;
      bc_base      = bc_ff;
      fill_base    = fill_ff;
      len_ok_cur   = pad_first_ff ? (fill_ff <= 6'd55) : len_ok_ff;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!open_ff) begin
                  cv_in     = iv_ff;
                  bc_base   = {3'b000, req_tdata[68:8]};
                  fill_base = '0;
               end
               open_in = 1'b1;
               bc_in   = bc_base;
               fill_in = fill_base;
               if (req_tlast) begin
                  pad_first_in = 1'b1;
               end
               if (req_tuser) begin
                  ctrl.shift_en   = 1'b1;
                  ctrl.shift_byte = req_tdata[7:0];
                  fill_in         = fill_base + 6'd1;
                  bc_in           = bc_base + 64'd1;
               end
               if (req_tuser && fill_base == 6'd63) begin
                  state_in = ST_COMP;
                  start_in = 1'b1;
                  ret_in   = req_tlast ? ST_PAD : ST_IDLE;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctrl.shift_en = 1'b1;
            if (pad_first_ff) begin
               ctrl.shift_byte = PAD_BYTE;
            end else if (len_ok_ff && fill_ff >= 6'd56) begin
               ctrl.shift_byte = 8'(bits >> {~fill_ff[2:0], 3'b000});
            end
            pad_first_in = 1'b0;
            len_ok_in    = len_ok_cur;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in  = ST_COMP;
               start_in  = 1'b1;
               ret_in    = len_ok_cur ? ST_OUT : ST_PAD;
               len_ok_in = 1'b1;
            end
         end
         ST_COMP: begin
            ctrl.start = start_ff;
            if (stat.done) begin
               cv_in    = result;
               state_in = ret_ff;
               idx_in   = '0;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  open_in  = 1'b0;
                  fill_in  = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      cv_ff  <= cv_in;
      bc_ff  <= bc_in;
      ret_ff <= ret_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         open_ff      <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         idx_ff       <= '0;
         start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
      end
   end

   sm3_round_unit u_round (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cv     (cv_ff),
      .stat   (stat),
      .result (result)
   );

   // Output word.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'b00000, idx_ff, cv_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

   `ASSERT_IMPL(a_sides_apart, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_NEXT(a_close_msg, clock, reset, rsp_acc && rsp_tlast, req_tready && !open_ff)
   `ASSERT_NEXT(a_pad_block, clock, reset, state_ff == ST_PAD && fill_ff == 6'd63,
                state_ff == ST_COMP && start_ff)

endmodule
